FILE: sv/pbrp_pkg.sv
// pbrp_pkg: shared types, constants and the prime ROM of the rehash policy engine.
// No dependencies; imported by the top level, pbrp_arith and pbrp_search.

package pbrp_pkg;

  // Field widths
  localparam int unsigned WORD_W   = 32;                       // bucket/element counts
  localparam int unsigned LOAD_W   = 24;                       // Q8.16 load factor
  localparam int unsigned FRAC_W   = 16;                       // fraction bits of the load
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned NUM_W    = WORD_W + 1 + FRAC_W;      // (33-bit total) << 16
  localparam int unsigned PROD_W   = WORD_W + LOAD_W;          // word x load product
  localparam int unsigned CEIL_W   = PROD_W - FRAC_W + 1;      // rounded-up product >> 16
  localparam int unsigned QC_W     = NUM_W + 1;                // quotient plus round-up

  // Serial arithmetic step counts
  localparam int unsigned MUL_STEPS = LOAD_W;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned ACNT_W    = $clog2(DIV_STEPS);

  // Prime ROM
  localparam int unsigned PRIME_TABLE_SIZE = 256;
  localparam int unsigned ROM_LEN          = 256;
  localparam int unsigned ROM_AW           = $clog2(ROM_LEN);
  localparam int unsigned CUR_W            = ROM_AW + 1;       // search bounds reach ROM_LEN
  localparam logic [WORD_W-1:0] TOP_PRIME  = 32'd4294967291;
  localparam logic [WORD_W-1:0] WORD_MAX   = '1;

  // APB register map
  localparam int unsigned ADDR_W       = 3;
  localparam int unsigned APB_DW       = 32;
  localparam logic [0:0]  REG_LOAD_IDX = 1'b0;
  localparam logic [LOAD_W-1:0] LOAD_RESET = 24'd65536;        // 1.0 in Q8.16

  // Query kinds
  localparam logic [KIND_W-1:0] KIND_REHASH    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NEXT      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PREV      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SIZE      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PREV_KEEP = 3'd4;

  typedef enum logic [0:0] {
    ARITH_MUL,
    ARITH_DIV
  } arith_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL_BL,
    ST_DIV,
    ST_SIZE,
    ST_SEARCH,
    ST_THRESH,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                start;
    arith_op_e           op;
    logic [NUM_W-1:0]    opa;     // multiplicand in low bits, or dividend
  } arith_req_t;

  typedef struct packed {
    logic                done;
    logic                rem_nz;
    logic [PROD_W-1:0]   prod;    // product, or quotient in low bits
  } arith_rsp_t;

  typedef struct packed {
    logic                start;
    logic                below;   // last prime <= value, else first prime >= value
    logic [WORD_W-1:0]   value;
  } search_req_t;

  typedef struct packed {
    logic                done;
    logic [WORD_W-1:0]   prime;
  } search_rsp_t;

  localparam logic [WORD_W-1:0] PRIME_ROM [ROM_LEN] = '{
    32'd2, 32'd3, 32'd5, 32'd7, 32'd11, 32'd13, 32'd17, 32'd19, 32'd23, 32'd29, 32'd31,
    32'd37, 32'd41, 32'd43, 32'd47, 32'd53, 32'd59, 32'd61, 32'd67, 32'd71, 32'd73,
    32'd79, 32'd83, 32'd89, 32'd97, 32'd103, 32'd109, 32'd113, 32'd127, 32'd137, 32'd139,
    32'd149, 32'd157, 32'd167, 32'd179, 32'd193, 32'd199, 32'd211, 32'd227, 32'd241,
    32'd257, 32'd277, 32'd293, 32'd313, 32'd337, 32'd359, 32'd383, 32'd409, 32'd439,
    32'd467, 32'd503, 32'd541, 32'd577, 32'd619, 32'd661, 32'd709, 32'd761, 32'd823,
    32'd887, 32'd953, 32'd1031, 32'd1109, 32'd1193, 32'd1289, 32'd1381, 32'd1493,
    32'd1613, 32'd1741, 32'd1879, 32'd2029, 32'd2179, 32'd2357, 32'd2549, 32'd2753,
    32'd2971, 32'd3209, 32'd3469, 32'd3739, 32'd4027, 32'd4349, 32'd4703, 32'd5087,
    32'd5503, 32'd5953, 32'd6427, 32'd6949, 32'd7517, 32'd8123, 32'd8783, 32'd9497,
    32'd10273, 32'd11113, 32'd12011, 32'd12983, 32'd14033, 32'd15173, 32'd16411,
    32'd17749, 32'd19183, 32'd20753, 32'd22447, 32'd24281, 32'd26267, 32'd28411,
    32'd30727, 32'd33223, 32'd35933, 32'd38873, 32'd42043, 32'd45481, 32'd49201,
    32'd53201, 32'd57557, 32'd62233, 32'd67307, 32'd72817, 32'd78779, 32'd85229,
    32'd92203, 32'd99733, 32'd107897, 32'd116731, 32'd126271, 32'd136607, 32'd147793,
    32'd159871, 32'd172933, 32'd187091, 32'd202409, 32'd218971, 32'd236897, 32'd256279,
    32'd277261, 32'd299951, 32'd324503, 32'd351061, 32'd379787, 32'd410857, 32'd444487,
    32'd480881, 32'd520241, 32'd562841, 32'd608903, 32'd658753, 32'd712697, 32'd771049,
    32'd834181, 32'd902483, 32'd976369, 32'd1056323, 32'd1142821, 32'd1236397,
    32'd1337629, 32'd1447153, 32'd1565659, 32'd1693859, 32'd1832561, 32'd1982627,
    32'd2144977, 32'd2320627, 32'd2510653, 32'd2716249, 32'd2938679, 32'd3179303,
    32'd3439651, 32'd3721303, 32'd4026031, 32'd4355707, 32'd4712381, 32'd5098259,
    32'd5515729, 32'd5967347, 32'd6456007, 32'd6984629, 32'd7556579, 32'd8175383,
    32'd8844859, 32'd9569143, 32'd10352717, 32'd11200489, 32'd12117689, 32'd13109983,
    32'd14183539, 32'd15345007, 32'd16601593, 32'd17961079, 32'd19431899, 32'd21023161,
    32'd22744717, 32'd24607243, 32'd26622317, 32'd28802401, 32'd31160981, 32'd33712729,
    32'd36473443, 32'd39460231, 32'd42691603, 32'd46187573, 32'd49969847, 32'd54061849,
    32'd58488943, 32'd63278561, 32'd68460391, 32'd74066549, 32'd80131819, 32'd86693767,
    32'd93793069, 32'd101473717, 32'd109783337, 32'd118773397, 32'd128499677,
    32'd139022417, 32'd150406843, 32'd162723577, 32'd176048909, 32'd190465427,
    32'd206062531, 32'd222936881, 32'd241193053, 32'd260944219, 32'd282312799,
    32'd305431229, 32'd330442829, 32'd357502601, 32'd386778277, 32'd418451333,
    32'd452718089, 32'd489790921, 32'd529899637, 32'd573292817, 32'd620239453,
    32'd671030513, 32'd725980837, 32'd785430967, 32'd849749479, 32'd919334987,
    32'd994618837, 32'd1076067617, 32'd1164186217, 32'd1259520799, 32'd1362662261,
    32'd1474249943, 32'd1594975441, 32'd1725587117, 32'd1866894511, 32'd2019773507,
    32'd2185171673, 32'd2364114217, 32'd2557710269, 32'd2767159799, 32'd2993761039,
    32'd3238918481, 32'd3504151727, 32'd3791104843, 32'd4101556399, 32'd4294967291
  };

endpackage

FILE: sv/prime_bucket_rehash_policy.sv
// prime_bucket_rehash_policy: hash-table sizing engine, top level and sequencer.
// Depends on pbrp_pkg, pbrp_arith (serial mul/div) and pbrp_search (prime ROM search).
//
//  Channel   Dir  Beat contents
//  s_axis    in   tdata: bucket_count, element_count, element_add, count_hint; tuser: kind
//  m_axis    out  tdata: prime; tuser: rehash_needed
//  apb       in   max_load_factor at byte address 0 (Q8.16, 24 bits)
//
// One query at a time. A rehash check that stays under the threshold and an unused kind
// go straight to the result; a previous prime without update runs a ROM search only; the
// other prime queries add a threshold multiply after the search; a rehash check that only
// refreshes the threshold runs two multiplies; sizing runs a divide, a search and a
// threshold multiply, and a rehash that resizes runs a multiply before those; these steps
// use the serial multiplier, the serial divider and the ROM search.
// A result waits in the output register; the next query is taken meanwhile and stalls
// only at its end if the previous result is still held. Reset: load 1.0, threshold 0.

module prime_bucket_rehash_policy #(
  parameter int unsigned PrimeTableSize = pbrp_pkg::PRIME_TABLE_SIZE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // query stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // [31:0] bucket_count, [63:32] element_count,
                                      // [95:64] element_add, [127:96] count_hint
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] prime
  output logic [0:0]  m_axis_tuser,   // [0] rehash_needed
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [pbrp_pkg::ADDR_W-1:0] paddr,
  input  logic [pbrp_pkg::APB_DW-1:0] pwdata,
  output logic [pbrp_pkg::APB_DW-1:0] prdata,
  output logic        pready
);
  import pbrp_pkg::*;

  state_e              state_q, state_d;
  logic [KIND_W-1:0]   kind_q;
  logic [WORD_W:0]     num_q;        // total or element_count
  logic [WORD_W-1:0]   opnd_q;       // effective buckets or hint
  logic [WORD_W-1:0]   thr_q, thr_d;
  logic [LOAD_W-1:0]   load_q;
  logic [WORD_W-1:0]   res_prime_q, res_prime_d;
  logic                res_flag_q, res_flag_d;
  logic                out_valid_q, out_valid_d;
  logic [WORD_W-1:0]   out_prime_q;
  logic                out_flag_q;
  logic                out_load;

  logic                s_accept;
  logic                cfg_wr;
  logic [WORD_W-1:0]   in_bc, in_ec, in_ea, in_hint;
  logic [WORD_W:0]     in_total;

  arith_req_t          arith_req;
  arith_rsp_t          arith_rsp;
  search_req_t         search_req;
  search_rsp_t         search_rsp;

  logic [NUM_W-1:0]    num_scaled;
  logic [NUM_W-1:0]    quot;
  logic [WORD_W-1:0]   quot_sat;
  logic [QC_W-1:0]     quot_ceil;
  logic [WORD_W-1:0]   ceil_sat;
  logic [WORD_W:0]     twice_b;
  logic [WORD_W-1:0]   need;
  logic [CEIL_W-1:0]   thr_ceil;
  logic [WORD_W-1:0]   thr_sat;

  // Input beat unpacking
  assign in_bc    = s_axis_tdata[WORD_W-1:0];
  assign in_ec    = s_axis_tdata[2*WORD_W-1:WORD_W];
  assign in_ea    = s_axis_tdata[3*WORD_W-1:2*WORD_W];
  assign in_hint  = s_axis_tdata[4*WORD_W-1:3*WORD_W];
  assign in_total = {1'b0, in_ec} + {1'b0, in_ea};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2:2] == REG_LOAD_IDX);
  assign prdata = (paddr[2:2] == REG_LOAD_IDX) ? {{(APB_DW-LOAD_W){1'b0}}, load_q} : '0;

  // Sizing arithmetic on the unit's result
  assign num_scaled = {num_q, {FRAC_W{1'b0}}};
  assign quot       = arith_rsp.prod[NUM_W-1:0];
  assign quot_sat   = (quot[NUM_W-1:WORD_W] != '0) ? WORD_MAX : quot[WORD_W-1:0];
  assign quot_ceil  = {1'b0, quot} + {{(QC_W-1){1'b0}}, arith_rsp.rem_nz};
  assign ceil_sat   = (quot_ceil[QC_W-1:WORD_W] != '0) ? WORD_MAX : quot_ceil[WORD_W-1:0];
  assign twice_b    = {opnd_q, 1'b0};
  always_comb begin
    if (kind_q == KIND_SIZE) begin
      need = ceil_sat;
    end else if (twice_b > {1'b0, quot_sat}) begin
      need = twice_b[WORD_W] ? WORD_MAX : twice_b[WORD_W-1:0];
    end else begin
      need = quot_sat;
    end
  end

  // Threshold: ceil(product / 2^16), saturated
  assign thr_ceil = {1'b0, arith_rsp.prod[PROD_W-1:FRAC_W]}
                  + {{(CEIL_W-1){1'b0}}, (arith_rsp.prod[FRAC_W-1:0] != '0)};
  assign thr_sat  = (thr_ceil[CEIL_W-1:WORD_W] != '0) ? WORD_MAX : thr_ceil[WORD_W-1:0];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    thr_d       = thr_q;
    res_prime_d = res_prime_q;
    res_flag_d  = res_flag_q;
    out_load    = 1'b0;
    arith_req   = '{start: 1'b0, op: ARITH_MUL, opa: '0};
    search_req  = '{start: 1'b0, below: 1'b0, value: opnd_q};
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        res_prime_d = '0;
        res_flag_d  = 1'b0;
        case (kind_q)
          KIND_REHASH: begin
            if (num_q > {1'b0, thr_q}) begin
              arith_req = '{start: 1'b1, op: ARITH_MUL,
                            opa: {{(NUM_W-WORD_W){1'b0}}, opnd_q}};
              state_d   = ST_MUL_BL;
            end else begin
              state_d = ST_FIN;
            end
          end
          KIND_NEXT: begin
            search_req.start = 1'b1;
            state_d          = ST_SEARCH;
          end
          KIND_PREV, KIND_PREV_KEEP: begin
            search_req.start = 1'b1;
            search_req.below = 1'b1;
            state_d          = ST_SEARCH;
          end
          KIND_SIZE: begin
            arith_req = '{start: 1'b1, op: ARITH_DIV, opa: num_scaled};
            state_d   = ST_DIV;
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end
      ST_MUL_BL: begin
        if (arith_rsp.done) begin
          if ({{(PROD_W-NUM_W){1'b0}}, num_scaled} > arith_rsp.prod) begin
            arith_req = '{start: 1'b1, op: ARITH_DIV, opa: num_scaled};
            state_d   = ST_DIV;
          end else begin
            // load already fine for these buckets: refresh threshold only
            arith_req = '{start: 1'b1, op: ARITH_MUL,
                          opa: {{(NUM_W-WORD_W){1'b0}}, opnd_q}};
            state_d   = ST_THRESH;
          end
        end
      end
      ST_DIV: begin
        if (arith_rsp.done) begin
          state_d = ST_SIZE;
        end
      end
      ST_SIZE: begin
        search_req.start = 1'b1;
        search_req.value = need;
        state_d          = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (search_rsp.done) begin
          res_prime_d = search_rsp.prime;
          res_flag_d  = (kind_q == KIND_REHASH);
          if (kind_q == KIND_PREV_KEEP) begin
            state_d = ST_FIN;
          end else begin
            arith_req = '{start: 1'b1, op: ARITH_MUL,
                          opa: {{(NUM_W-WORD_W){1'b0}}, search_rsp.prime}};
            state_d   = ST_THRESH;
          end
        end
      end
      ST_THRESH: begin
        if (arith_rsp.done) begin
          thr_d   = thr_sat;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= '0;
      load_q      <= LOAD_RESET;
      out_valid_q <= 1'b0;
      out_prime_q <= '0;
      out_flag_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      thr_q       <= thr_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        load_q <= pwdata[LOAD_W-1:0];
      end
      if (out_load) begin
        out_prime_q <= res_prime_q;
        out_flag_q  <= res_flag_q;
      end
    end
  end

  // Query capture and result payload
  always_ff @(posedge clk_i) begin
    res_prime_q <= res_prime_d;
    res_flag_q  <= res_flag_d;
    if (s_accept) begin
      kind_q <= s_axis_tuser;
      num_q  <= (s_axis_tuser == KIND_REHASH) ? in_total : {1'b0, in_ec};
      if (s_axis_tuser == KIND_REHASH) begin
        opnd_q <= (in_bc == WORD_W'(1)) ? '0 : in_bc;  // one bucket counts as none
      end else begin
        opnd_q <= in_hint;
      end
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_prime_q;
  assign m_axis_tuser[0] = out_flag_q;

  pbrp_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arith_req),
    .load_i (load_q),
    .rsp_o  (arith_rsp)
  );

  pbrp_search #(
    .TableSize (PrimeTableSize)
  ) u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (search_req),
    .rsp_o  (search_rsp)
  );

endmodule

FILE: sv/pbrp_arith.sv
// pbrp_arith: bit-serial shift-add multiplier and restoring divider, shared unit.
// Depends on pbrp_pkg (request/response structs, widths, step counts).

module pbrp_arith (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pbrp_pkg::arith_req_t  req_i,
  input  logic [pbrp_pkg::LOAD_W-1:0] load_i,
  output pbrp_pkg::arith_rsp_t  rsp_o
);
  import pbrp_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [ACNT_W-1:0]   cnt_q, cnt_d;
  arith_op_e           op_q, op_d;
  logic [PROD_W-1:0]   acc_q, acc_d;
  logic [WORD_W-1:0]   mcand_q, mcand_d;
  logic [LOAD_W-1:0]   dvsr_q, dvsr_d;
  logic [LOAD_W-1:0]   rem_q, rem_d;

  logic [WORD_W:0]     mul_sum;
  logic [LOAD_W:0]     trial;
  logic [LOAD_W:0]     rem_nx;
  logic                ge;
  logic                last;

  // One multiplier bit or one quotient bit per cycle
  assign mul_sum = {1'b0, acc_q[PROD_W-1:LOAD_W]}
                 + (acc_q[0] ? {1'b0, mcand_q} : '0);
  assign trial   = {rem_q, acc_q[NUM_W-1]};
  assign ge      = (trial >= {1'b0, dvsr_q});
  assign rem_nx  = ge ? (trial - {1'b0, dvsr_q}) : trial;
  assign last    = (op_q == ARITH_MUL) ? (cnt_q == ACNT_W'(MUL_STEPS - 1))
                                       : (cnt_q == ACNT_W'(DIV_STEPS - 1));

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    op_d    = op_q;
    acc_d   = acc_q;
    mcand_d = mcand_q;
    dvsr_d  = dvsr_q;
    rem_d   = rem_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      op_d    = req_i.op;
      mcand_d = req_i.opa[WORD_W-1:0];
      dvsr_d  = load_i;
      rem_d   = '0;
      if (req_i.op == ARITH_MUL) begin
        acc_d = {{(PROD_W-LOAD_W){1'b0}}, load_i};
      end else begin
        acc_d = {{(PROD_W-NUM_W){1'b0}}, req_i.opa};
      end
    end else if (busy_q) begin
      if (op_q == ARITH_MUL) begin
        acc_d = {mul_sum, acc_q[LOAD_W-1:1]};
      end else begin
        acc_d = {acc_q[PROD_W-1:NUM_W], acc_q[NUM_W-2:0], ge};
        rem_d = rem_nx[LOAD_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ARITH_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    dvsr_q  <= dvsr_d;
    rem_q   <= rem_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.rem_nz = (rem_q != '0);
  assign rsp_o.prod   = acc_q;

endmodule

FILE: sv/pbrp_search.sv
// pbrp_search: binary search of the sorted prime ROM, one probe per cycle.
// Depends on pbrp_pkg (PRIME_ROM, request/response structs).

module pbrp_search #(
  parameter int unsigned TableSize = pbrp_pkg::PRIME_TABLE_SIZE
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pbrp_pkg::search_req_t req_i,
  output pbrp_pkg::search_rsp_t rsp_o
);
  import pbrp_pkg::*;

  localparam logic [CUR_W-1:0] TableEnd = CUR_W'(TableSize);

  logic               busy_q, busy_d;
  logic               fin_q, fin_d;
  logic               done_q, done_d;
  logic [CUR_W-1:0]   lo_q, lo_d;
  logic [CUR_W-1:0]   hi_q, hi_d;
  logic               below_q, below_d;
  logic [WORD_W-1:0]  value_q, value_d;
  logic [WORD_W-1:0]  prime_q, prime_d;

  logic [CUR_W-1:0]   mid;
  logic [CUR_W-1:0]   lo_m1;
  logic [ROM_AW-1:0]  idx;
  logic [WORD_W-1:0]  entry;
  logic               go_right;
  logic               past_end;

  // Probe at mid while searching, at the answer slot in the final cycle
  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign lo_m1    = lo_q - 1'b1;
  assign idx      = !fin_q   ? mid[ROM_AW-1:0] :
                    !below_q ? lo_q[ROM_AW-1:0] :
                    (lo_q == '0) ? '0 : lo_m1[ROM_AW-1:0];
  assign entry    = PRIME_ROM[idx];
  assign go_right = below_q ? (entry <= value_q) : (entry < value_q);
  assign past_end = !below_q && (lo_q == TableEnd);

  always_comb begin
    busy_d  = busy_q;
    fin_d   = fin_q;
    done_d  = 1'b0;
    lo_d    = lo_q;
    hi_d    = hi_q;
    below_d = below_q;
    value_d = value_q;
    prime_d = prime_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      fin_d   = 1'b0;
      lo_d    = '0;
      hi_d    = TableEnd;
      below_d = req_i.below;
      value_d = req_i.value;
    end else if (busy_q && fin_q) begin
      prime_d = past_end ? TOP_PRIME : entry;
      busy_d  = 1'b0;
      fin_d   = 1'b0;
      done_d  = 1'b1;
    end else if (busy_q) begin
      if (lo_q < hi_q) begin
        if (go_right) begin
          lo_d = mid + 1'b1;
        end else begin
          hi_d = mid;
        end
      end else begin
        fin_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    below_q <= below_d;
    value_q <= value_d;
    prime_q <= prime_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.prime = prime_q;

endmodule

FILE: sv/pbrp_checker.sv
// pbrp_checker: port-level assertions for prime_bucket_rehash_policy, with its bind.
// Depends on the top level's port names only.

module pbrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic s_beat;
  assign s_beat = s_axis_tvalid && s_axis_tready;

  // A stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  // One query in flight: no second beat right after an accept
  a_one_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat |=> !s_axis_tready)
    else $error("query accepted while another is in flight");

  // A fresh query cannot reach the output register in the cycle after its accept
  a_no_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat |=> $stable(m_axis_tdata))
    else $error("result register changed directly after an accept");

  // A demanded resize always names a real prime
  a_flag_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata != 32'd0)
    else $error("rehash flagged with zero prime");

endmodule

bind prime_bucket_rehash_policy pbrp_checker u_pbrp_checker (.*);
